>>> design/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg - button gesture classifier shared definitions
// Event codes, configuration register indexes, register defaults and the
// configuration register bundle.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int NOW_W     = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 4;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_HOLD   = 2'd3
	} event_t;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TAP    = 4'd3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] HOLD_RST       = 16'd1000;
	localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd300;
	localparam logic [CFG_W-1:0] MIN_TAP_RST    = 16'd80;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] hold_time;
		logic [CFG_W-1:0] double_gap_time;
		logic [CFG_W-1:0] min_tap_time;
	} cfg_t;

endpackage

>>> design/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier - debounced click, double click and hold detector
// Classifies polls of an active-low button into single click, double click
// and hold events, and reports the debounced pressed level.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    raw_level, now_ms
//  out      out_valid / out_stall  event_res, led_on
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One poll per cycle sustained while the output is not stalled; a request
//  passes through the input register, one classification pass and the
//  result register. Reset loads the default timings and a released button.
//  A stalled result holds in the result register while the input register
//  takes one more request; the input stalls only when both are full.
// ----------------------------------------------------------------------------
module button_gesture_classifier #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          raw_level,
	input  logic [bgc_pkg::NOW_W-1:0]     now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    event_res,
	output logic                          led_on,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgc_pkg::CFG_W-1:0]     cfg_data
);

	logic                      valid_s1;
	logic                      raw_s1;
	logic [bgc_pkg::NOW_W-1:0] now_s1;
	logic                      out_valid_q;
	bgc_pkg::event_t           event_q;
	logic                      led_q;
	logic                      adv;
	bgc_pkg::cfg_t             cfg;
	bgc_pkg::event_t           event_nxt;
	logic                      led_nxt;

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign led_on    = led_q;

	bgc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bgc_engine #(.TIME_WIDTH(TIME_WIDTH)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.raw_level (raw_s1),
		.now_ms    (now_s1),
		.cfg       (cfg),
		.event_nxt (event_nxt),
		.led_nxt   (led_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_s1 <= raw_level;
			now_s1 <= now_ms;
		end
		if (adv) begin
			event_q <= event_nxt;
			led_q   <= led_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("classified request lost");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(now_s1) && $stable(raw_s1)))
		else $error("waiting request dropped or changed");
`endif

endmodule

>>> design/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs - configuration register file
// Four 16-bit timing registers written through a valid/ready request port.
// Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module bgc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgc_pkg::CFG_W-1:0]      cfg_data,
	output bgc_pkg::cfg_t                  cfg
);

	bgc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= bgc_pkg::DEBOUNCE_RST;
			cfg_q.hold_time       <= bgc_pkg::HOLD_RST;
			cfg_q.double_gap_time <= bgc_pkg::DOUBLE_GAP_RST;
			cfg_q.min_tap_time    <= bgc_pkg::MIN_TAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bgc_pkg::REG_DEBOUNCE:   cfg_q.debounce_time   <= cfg_data;
				bgc_pkg::REG_HOLD:       cfg_q.hold_time       <= cfg_data;
				bgc_pkg::REG_DOUBLE_GAP: cfg_q.double_gap_time <= cfg_data;
				bgc_pkg::REG_MIN_TAP:    cfg_q.min_tap_time    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> design/bgc_engine.sv
// ----------------------------------------------------------------------------
// bgc_engine - debounce and gesture state
// Holds the debounce and gesture state and classifies one poll per enabled
// cycle. Event and debounced level are combinational from the poll and state.
// ----------------------------------------------------------------------------
module bgc_engine #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          raw_level,
	input  logic [bgc_pkg::NOW_W-1:0]     now_ms,
	input  bgc_pkg::cfg_t                 cfg,
	output bgc_pkg::event_t               event_nxt,
	output logic                          led_nxt
);

	logic                  last_raw_q;
	logic [TIME_WIDTH-1:0] debounce_start_q;
	logic                  stable_pressed_q;
	logic [TIME_WIDTH-1:0] press_start_q;
	logic                  tap_pending_q;
	logic [TIME_WIDTH-1:0] first_tap_time_q;
	logic                  hold_taken_q;

	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] deb_t, hold_t, gap_t, min_t;
	logic [TIME_WIDTH-1:0] db_start_n, db_el, gap_el, dur, ps_n, ft_n, gap1_el, hold_el;
	logic                  settled, pressed, changed, released_tap, is_double;
	logic                  tp1, ht1, hold_hit, single_early, single_late;
	logic                  sp_d, tp_d, ht_d;
	bgc_pkg::event_t       ev_d;

	assign now_t  = TIME_WIDTH'(now_ms);
	assign deb_t  = TIME_WIDTH'(cfg.debounce_time);
	assign hold_t = TIME_WIDTH'(cfg.hold_time);
	assign gap_t  = TIME_WIDTH'(cfg.double_gap_time);
	assign min_t  = TIME_WIDTH'(cfg.min_tap_time);

	always_comb begin
		db_start_n   = (raw_level != last_raw_q) ? now_t : debounce_start_q;
		db_el        = now_t - db_start_n;
		settled      = !(db_el < deb_t);
		gap_el       = now_t - first_tap_time_q;
		single_early = tap_pending_q && (gap_el > gap_t);

		pressed      = !raw_level;
		changed      = pressed != stable_pressed_q;
		dur          = now_t - press_start_q;
		released_tap = changed && !pressed && !hold_taken_q &&
			(dur >= min_t) && (dur < hold_t);
		is_double    = released_tap && tap_pending_q && (gap_el <= gap_t);

		ps_n = (changed && pressed) ? now_t : press_start_q;
		ht1  = changed ? 1'b0 : hold_taken_q;
		tp1  = tap_pending_q;
		ft_n = first_tap_time_q;
		if (released_tap && !is_double) begin
			tp1  = 1'b1;
			ft_n = now_t;
		end

		hold_el     = now_t - ps_n;
		hold_hit    = pressed && !ht1 && (hold_el >= hold_t);
		gap1_el     = now_t - ft_n;
		single_late = tp1 && (gap1_el > gap_t);

		sp_d = stable_pressed_q;
		tp_d = tap_pending_q;
		ht_d = hold_taken_q;
		ev_d = bgc_pkg::EV_NONE;
		if (!settled) begin
			if (single_early) begin
				tp_d = 1'b0;
				ev_d = bgc_pkg::EV_SINGLE;
			end
		end else begin
			sp_d = pressed;
			ht_d = ht1;
			tp_d = tp1;
			if (is_double) begin
				tp_d = 1'b0;
				ev_d = bgc_pkg::EV_DOUBLE;
			end else if (hold_hit) begin
				ht_d = 1'b1;
				tp_d = 1'b0;
				ev_d = bgc_pkg::EV_HOLD;
			end else if (single_late) begin
				tp_d = 1'b0;
				ev_d = bgc_pkg::EV_SINGLE;
			end
		end
	end

	assign event_nxt = ev_d;
	assign led_nxt   = sp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q       <= 1'b1;
			debounce_start_q <= '0;
			stable_pressed_q <= 1'b0;
			press_start_q    <= '0;
			tap_pending_q    <= 1'b0;
			first_tap_time_q <= '0;
			hold_taken_q     <= 1'b0;
		end else if (en) begin
			last_raw_q       <= raw_level;
			debounce_start_q <= db_start_n;
			stable_pressed_q <= sp_d;
			tap_pending_q    <= tp_d;
			hold_taken_q     <= ht_d;
			if (settled) begin
				press_start_q    <= ps_n;
				first_tap_time_q <= ft_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_hold_while_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ev_d == bgc_pkg::EV_HOLD) |-> sp_d)
		else $error("hold event without debounced press");

	a_double_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ev_d == bgc_pkg::EV_DOUBLE) |-> (!sp_d && stable_pressed_q))
		else $error("double click outside a release");

	a_hold_marks_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ev_d == bgc_pkg::EV_HOLD) |=> (hold_taken_q && !tap_pending_q))
		else $error("hold event did not mark hold taken");
`endif

endmodule
